// ----- design/qcr_pkg.sv -----
// shared constants, codes and types for the quadrature counter with speed unit
package qcr_pkg;

    // default counter width
    localparam int COUNT_WIDTH_DEF = 32;

    // minutes to milliseconds scale used by the speed formula
    localparam int          SCALE_WIDTH = 16;
    localparam int          SCALE_IDX_W = 4;
    localparam logic [15:0] RPM_SCALE   = 16'd60000;

    // divisor is counts_per_revolution (16 bits) times elapsed ms (32 bits)
    localparam int DIV_WIDTH = 48;

    // reset value of counts_per_revolution
    localparam logic [15:0] CPR_RESET = 16'd1024;

    // event kinds carried on the input tuser
    localparam logic [1:0] CMD_EDGE_A = 2'd0;
    localparam logic [1:0] CMD_EDGE_B = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    // speed status codes carried on the output tuser
    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_EDGE     = 2'd1;
    localparam logic [1:0] ST_ZERO_DIV = 2'd2;
    localparam logic [1:0] ST_SAT      = 2'd3;

    // speed unit sequencer states
    typedef enum logic [2:0] {
        SPD_IDLE,
        SPD_LOAD,
        SPD_SCALE,
        SPD_DIVIDE,
        SPD_DONE
    } spd_state_t;

    // result handed from the speed unit to the top level
    typedef struct packed {
        logic        done;
        logic        sat;
        logic [31:0] rpm;
    } speed_res_t;

endpackage

// ----- design/qcr_speed_unit.sv -----
// iterative speed unit: divisor product, shift-add scale by 60000, restoring division
module qcr_speed_unit #(
    parameter int COUNT_WIDTH = qcr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic                   neg,
    input  logic [COUNT_WIDTH-1:0] mag,
    input  logic [15:0]            cpr,
    input  logic [31:0]            dt,
    output qcr_pkg::speed_res_t    res
);

    localparam int NW   = COUNT_WIDTH + qcr_pkg::SCALE_WIDTH;
    localparam int DW   = qcr_pkg::DIV_WIDTH;
    localparam int CNTW = $clog2(NW);

    localparam logic [32:0] LIMIT_POS = 33'h0_7FFF_FFFF;
    localparam logic [32:0] LIMIT_NEG = 33'h0_8000_0000;

    qcr_pkg::spd_state_t state_reg, state_next;

    logic [CNTW-1:0]        cnt_reg, cnt_next;
    logic [NW-1:0]          acc_reg, acc_next;
    logic [DW-1:0]          rem_reg, rem_next;
    logic [DW-1:0]          div_reg, div_next;
    logic [32:0]            q_reg, q_next;
    logic                   ovf_reg, ovf_next;
    logic                   neg_reg, neg_next;
    logic [COUNT_WIDTH-1:0] mag_reg, mag_next;
    logic [15:0]            cpr_reg, cpr_next;
    logic [31:0]            dt_reg, dt_next;

    logic [DW:0]  shifted;
    logic         ge;
    logic [32:0]  limit;
    logic         sat;
    logic [31:0]  q_sel;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            qcr_pkg::SPD_IDLE: begin
                if (start) begin
                    state_next = qcr_pkg::SPD_LOAD;
                end
            end
            qcr_pkg::SPD_LOAD: begin
                state_next = qcr_pkg::SPD_SCALE;
            end
            qcr_pkg::SPD_SCALE: begin
                if (cnt_reg == '0) begin
                    state_next = qcr_pkg::SPD_DIVIDE;
                end
            end
            qcr_pkg::SPD_DIVIDE: begin
                if (cnt_reg == '0) begin
                    state_next = qcr_pkg::SPD_DONE;
                end
            end
            qcr_pkg::SPD_DONE: begin
                state_next = qcr_pkg::SPD_IDLE;
            end
            default: begin
                state_next = qcr_pkg::SPD_IDLE;
            end
        endcase
    end

    // one restoring division step
    assign shifted = {rem_reg, acc_reg[NW-1]};
    assign ge      = (shifted >= {1'b0, div_reg});

    // datapath updates per state
    always_comb begin
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        q_next   = q_reg;
        ovf_next = ovf_reg;
        neg_next = neg_reg;
        mag_next = mag_reg;
        cpr_next = cpr_reg;
        dt_next  = dt_reg;
        case (state_reg)
            qcr_pkg::SPD_IDLE: begin
                if (start) begin
                    neg_next = neg;
                    mag_next = mag;
                    cpr_next = cpr;
                    dt_next  = dt;
                end
            end
            qcr_pkg::SPD_LOAD: begin
                div_next = DW'(cpr_reg) * DW'(dt_reg);
                acc_next = '0;
                rem_next = '0;
                q_next   = '0;
                ovf_next = 1'b0;
                cnt_next = CNTW'(qcr_pkg::SCALE_WIDTH - 1);
            end
            qcr_pkg::SPD_SCALE: begin
                // msb-first shift-add of mag times the scale constant
                acc_next = {acc_reg[NW-2:0], 1'b0}
                         + (qcr_pkg::RPM_SCALE[cnt_reg[qcr_pkg::SCALE_IDX_W-1:0]]
                            ? NW'(mag_reg) : NW'(0));
                if (cnt_reg == '0) begin
                    cnt_next = CNTW'(NW - 1);
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            qcr_pkg::SPD_DIVIDE: begin
                if (ge) begin
                    rem_next = DW'(shifted - {1'b0, div_reg});
                end else begin
                    rem_next = shifted[DW-1:0];
                end
                acc_next = {acc_reg[NW-2:0], 1'b0};
                q_next   = {q_reg[31:0], ge};
                // quotient bits beyond 33 only matter as overflow
                ovf_next = ovf_reg | q_reg[32];
                cnt_next = cnt_reg - 1'b1;
            end
            qcr_pkg::SPD_DONE: begin
                cnt_next = cnt_reg;
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // result: saturate, then apply sign
    always_comb begin
        limit    = neg_reg ? LIMIT_NEG : LIMIT_POS;
        sat      = ovf_reg || (q_reg > limit);
        q_sel    = sat ? limit[31:0] : q_reg[31:0];
        res.done = (state_reg == qcr_pkg::SPD_DONE);
        res.sat  = sat;
        res.rpm  = neg_reg ? (~q_sel + 32'd1) : q_sel;
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= qcr_pkg::SPD_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        cpr_reg <= cpr_next;
        dt_reg  <= dt_next;
    end

endmodule

// ----- design/quadrature_counter_with_rpm_unit.sv -----
// Quadrature x2 position counter with rpm sampling. Each input beat is one event:
// a rising edge on A or B updates the count and returns its result in the next cycle,
// as does an unused kind or a speed sample whose divisor (counts per revolution times
// elapsed ms) is zero. A speed sample with a nonzero divisor runs through one shared
// sequential unit: a load step for the divisor product, shift-add steps for the
// scale by 60000, then COUNT_WIDTH+16 restoring division steps, one bit per cycle,
// and a done step to saturate and sign the result, which the output register then
// captures; the input is not ready while that unit runs. An output register holds
// each result, and a new event is taken while a finished result is being taken.
// counts_per_revolution is written through cfg_wr_en/cfg_wr_data; the user must write
// it only while the block is idle, and the block itself does not enforce this.
module quadrature_counter_with_rpm_unit #(
    parameter int COUNT_WIDTH = qcr_pkg::COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: counts_per_revolution
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // input events
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // level_a [0], level_b [1], now_ms [33:2], zero pad
    input  logic [1:0]  s_tuser,   // cmd [1:0]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // position [31:0], speed_rpm [63:32]
    output logic [1:0]  m_tuser    // speed_status [1:0]
);

    localparam int PW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] count_last_reg, count_last_next;
    logic [31:0]            time_last_reg, time_last_next;
    logic [15:0]            cpr_reg, cpr_next;
    logic                   busy_reg, busy_next;
    logic                   m_valid_reg, m_valid_next;
    logic [31:0]            m_pos_reg, m_pos_next;
    logic [31:0]            m_rpm_reg, m_rpm_next;
    logic [1:0]             m_status_reg, m_status_next;

    logic [1:0]             in_cmd;
    logic                   in_a;
    logic                   in_b;
    logic [31:0]            in_now;
    logic                   accept;
    logic [COUNT_WIDTH-1:0] delta;
    logic                   delta_neg;
    logic [COUNT_WIDTH-1:0] delta_mag;
    logic [31:0]            dt;
    logic                   zero_div;
    logic                   start;
    logic                   up;
    logic [PW-1:0]          pos_ext;
    qcr_pkg::speed_res_t    spd_res;

    // unpack the input beat
    assign in_cmd = s_tuser;
    assign in_a   = s_tdata[0];
    assign in_b   = s_tdata[1];
    assign in_now = s_tdata[33:2];

    assign s_tready = !busy_reg && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // speed inputs: signed count change and elapsed time since the last sample
    assign delta     = count_reg - count_last_reg;
    assign delta_neg = delta[COUNT_WIDTH-1];
    assign delta_mag = delta_neg ? (~delta + 1'b1) : delta;
    assign dt        = in_now - time_last_reg;
    assign zero_div  = (cpr_reg == 16'd0) || (dt == 32'd0);
    assign start     = accept && (in_cmd == qcr_pkg::CMD_SAMPLE) && !zero_div;

    qcr_speed_unit #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_speed (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (start),
        .neg    (delta_neg),
        .mag    (delta_mag),
        .cpr    (cpr_reg),
        .dt     (dt),
        .res    (spd_res)
    );

    // count direction for edge events
    assign up = (in_cmd == qcr_pkg::CMD_EDGE_A) ? (in_a != in_b) : (in_a == in_b);

    // position is the count sign-extended and cut to 32 bits
    assign pos_ext = PW'($signed(count_next));

    // counter state and sample snapshot
    always_comb begin
        count_next      = count_reg;
        count_last_next = count_last_reg;
        time_last_next  = time_last_reg;
        cpr_next        = cpr_reg;
        if (cfg_wr_en) begin
            cpr_next = cfg_wr_data;
        end
        if (accept) begin
            case (in_cmd)
                qcr_pkg::CMD_EDGE_A, qcr_pkg::CMD_EDGE_B: begin
                    count_next = up ? (count_reg + 1'b1) : (count_reg - 1'b1);
                end
                qcr_pkg::CMD_SAMPLE: begin
                    count_last_next = count_reg;
                    time_last_next  = in_now;
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // output register and busy flag
    always_comb begin
        busy_next     = busy_reg;
        m_valid_next  = m_valid_reg;
        m_pos_next    = m_pos_reg;
        m_rpm_next    = m_rpm_reg;
        m_status_next = m_status_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (start) begin
            busy_next = 1'b1;
        end else if (accept) begin
            // results known at once: edges, unused kind, zero divisor
            m_valid_next = 1'b1;
            m_pos_next   = pos_ext[31:0];
            m_rpm_next   = 32'd0;
            if (in_cmd == qcr_pkg::CMD_SAMPLE) begin
                m_status_next = qcr_pkg::ST_ZERO_DIV;
            end else begin
                m_status_next = qcr_pkg::ST_EDGE;
            end
        end
        if (spd_res.done) begin
            busy_next     = 1'b0;
            m_valid_next  = 1'b1;
            m_pos_next    = pos_ext[31:0];
            m_rpm_next    = spd_res.rpm;
            m_status_next = spd_res.sat ? qcr_pkg::ST_SAT : qcr_pkg::ST_VALID;
        end
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            count_last_reg <= '0;
            time_last_reg  <= '0;
            cpr_reg        <= qcr_pkg::CPR_RESET;
            busy_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            count_reg      <= count_next;
            count_last_reg <= count_last_next;
            time_last_reg  <= time_last_next;
            cpr_reg        <= cpr_next;
            busy_reg       <= busy_next;
            m_valid_reg    <= m_valid_next;
        end
        m_pos_reg    <= m_pos_next;
        m_rpm_reg    <= m_rpm_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_rpm_reg, m_pos_reg};
    assign m_tuser  = m_status_reg;

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for the quadrature x2 counter with rpm sampling
`timescale 1ns / 1ps

module testbench;

    // unused event kind, reports position only
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic [31:0] position;
        logic [31:0] speed_rpm;
        logic [1:0]  speed_status;
    } reading_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // level_a [0], level_b [1], now_ms [33:2], zero pad
    logic [1:0]  s_tuser = '0;    // cmd [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // position [31:0], speed_rpm [63:32]
    logic [1:0]  m_tuser;         // speed_status [1:0]

    // shadow of the encoder state and the divisor register
    logic [31:0] enc_count = '0;
    logic [31:0] count_snap = '0;
    logic [31:0] time_snap = '0;
    logic [15:0] cpr_shadow = qcr_pkg::CPR_RESET;

    reading_t expected_readings[$];
    int       mismatches = 0;
    int       cycle_count = 0;
    bit       steady = 1'b0;

    quadrature_counter_with_rpm_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[quadrature_counter_with_rpm_unit] ERROR");
            $finish;
        end
    end

    // random backpressure on the result side
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 23);
    end

    // apply one event to the shadow state and return the reading it yields
    function automatic reading_t advance_encoder(input logic [1:0] cmd, input logic a,
                                                 input logic b, input logic [31:0] now);
        reading_t    r;
        logic [31:0] delta;
        logic        neg;
        logic [63:0] mag;
        logic [31:0] elapsed;
        logic [63:0] divisor;
        logic [63:0] quot;
        logic [63:0] limit;
        r.speed_rpm = '0;
        r.speed_status = qcr_pkg::ST_EDGE;
        if (cmd == qcr_pkg::CMD_EDGE_A) begin
            enc_count = (a != b) ? enc_count + 32'd1 : enc_count - 32'd1;
        end else if (cmd == qcr_pkg::CMD_EDGE_B) begin
            enc_count = (a == b) ? enc_count + 32'd1 : enc_count - 32'd1;
        end else if (cmd == qcr_pkg::CMD_SAMPLE) begin
            delta = enc_count - count_snap;
            neg = delta[31];
            mag = {32'd0, neg ? (~delta + 32'd1) : delta};
            elapsed = now - time_snap;
            divisor = 64'(cpr_shadow) * 64'(elapsed);
            if (divisor == 0) begin
                r.speed_status = qcr_pkg::ST_ZERO_DIV;
            end else begin
                // exact truncated quotient, fits easily in 64 bits
                quot = (mag * 64'(qcr_pkg::RPM_SCALE)) / divisor;
                limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
                if (quot > limit) begin
                    quot = limit;
                    r.speed_status = qcr_pkg::ST_SAT;
                end else begin
                    r.speed_status = qcr_pkg::ST_VALID;
                end
                r.speed_rpm = neg ? (~quot[31:0] + 32'd1) : quot[31:0];
            end
            time_snap = now;
            count_snap = enc_count;
        end
        r.position = enc_count;
        return r;
    endfunction

    // send one event beat, with random gaps unless running steady
    task automatic send_event(input logic [1:0] cmd, input logic a, input logic b,
                              input logic [31:0] now);
        while (!steady && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {6'd0, now, b, a};
        do @(posedge aclk); while (!s_tready);
        expected_readings.push_back(advance_encoder(cmd, a, b, now));
    endtask

    // stop sending and wait for every outstanding reading
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
    endtask

    // write counts_per_revolution while the block is quiet
    task automatic set_cpr(input logic [15:0] value);
        wait_idle();
        @(posedge aclk);
        cfg_wr_data <= value;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cpr_shadow = value;
    endtask

    // compare each result beat with the oldest expected reading
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_readings.size() == 0) begin
                $error("unexpected result beat: position %0d", $signed(m_tdata[31:0]));
                mismatches++;
            end else begin
                want = expected_readings.pop_front();
                if (m_tdata[31:0] !== want.position) begin
                    $error("position mismatch: expected %0d, got %0d",
                           $signed(want.position), $signed(m_tdata[31:0]));
                    mismatches++;
                end
                if (m_tdata[63:32] !== want.speed_rpm) begin
                    $error("speed_rpm mismatch: expected %0d, got %0d",
                           $signed(want.speed_rpm), $signed(m_tdata[63:32]));
                    mismatches++;
                end
                if (m_tuser !== want.speed_status) begin
                    $error("speed_status mismatch: expected %0d, got %0d",
                           want.speed_status, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // every direction rule, the unused kind, zero elapsed time and time wrap
    task automatic test_edge_directions();
        send_event(qcr_pkg::CMD_EDGE_A, 1'b1, 1'b0, 32'h0000_0000);
        send_event(qcr_pkg::CMD_EDGE_A, 1'b0, 1'b1, 32'hFFFF_FFFF);
        send_event(qcr_pkg::CMD_EDGE_B, 1'b0, 1'b0, 32'hAAAA_AAAA);
        send_event(qcr_pkg::CMD_EDGE_B, 1'b1, 1'b1, 32'h5555_5555);
        send_event(qcr_pkg::CMD_EDGE_A, 1'b0, 1'b0, $urandom);
        send_event(qcr_pkg::CMD_EDGE_A, 1'b1, 1'b1, $urandom);
        send_event(qcr_pkg::CMD_EDGE_B, 1'b1, 1'b0, $urandom);
        send_event(qcr_pkg::CMD_EDGE_B, 1'b0, 1'b1, $urandom);
        send_event(qcr_pkg::CMD_EDGE_A, 1'b0, 1'b0, $urandom);
        send_event(qcr_pkg::CMD_EDGE_B, 1'b0, 1'b1, $urandom);
        send_event(qcr_pkg::CMD_EDGE_B, 1'b1, 1'b0, $urandom);
        send_event(CMD_SPARE, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_event(CMD_SPARE, 1'b0, 1'b0, 32'h0000_0000);
        // zero elapsed time right after reset
        send_event(qcr_pkg::CMD_SAMPLE, 1'b0, 1'b0, 32'h0000_0000);
        send_event(qcr_pkg::CMD_EDGE_A, 1'b1, 1'b1, $urandom);
        send_event(qcr_pkg::CMD_EDGE_A, 1'b0, 1'b0, $urandom);
        // negative speed truncated toward zero
        send_event(qcr_pkg::CMD_SAMPLE, 1'b1, 1'b0, 32'h0000_0001);
        send_event(qcr_pkg::CMD_SAMPLE, 1'b0, 1'b1, 32'hFFFF_FFFF);
        send_event(qcr_pkg::CMD_EDGE_B, 1'b1, 1'b1, $urandom);
        // elapsed time wraps past zero
        send_event(qcr_pkg::CMD_SAMPLE, 1'b1, 1'b1, 32'h0000_0000);
    endtask

    // smallest, largest and zero counts per revolution
    task automatic test_divisor_extremes();
        set_cpr(16'd1);
        repeat (3) send_event(qcr_pkg::CMD_EDGE_A, 1'b1, 1'b0, $urandom);
        send_event(qcr_pkg::CMD_SAMPLE, 1'b0, 1'b0, time_snap + 32'd1);
        set_cpr(16'd65535);
        send_event(qcr_pkg::CMD_EDGE_A, 1'b0, 1'b1, $urandom);
        send_event(qcr_pkg::CMD_SAMPLE, 1'b0, 1'b0, time_snap + 32'd1);
        set_cpr(16'd0);
        send_event(qcr_pkg::CMD_EDGE_B, 1'b0, 1'b0, $urandom);
        send_event(qcr_pkg::CMD_SAMPLE, 1'b1, 1'b1, time_snap + 32'd7);
    endtask

    // steady runs of edges at the smallest divisor for the highest speeds both ways
    task automatic test_top_speed();
        steady = 1'b1;
        set_cpr(16'd1);
        send_event(qcr_pkg::CMD_SAMPLE, 1'b0, 1'b0, 32'h1000_0000);
        repeat (30) send_event(qcr_pkg::CMD_EDGE_A, 1'b1, 1'b0, $urandom);
        send_event(qcr_pkg::CMD_SAMPLE, 1'b0, 1'b0, time_snap + 32'd1);
        repeat (50) send_event(qcr_pkg::CMD_EDGE_B, 1'b1, 1'b0, $urandom);
        send_event(qcr_pkg::CMD_SAMPLE, 1'b0, 1'b0, time_snap + 32'd1);
        repeat (20) send_event(qcr_pkg::CMD_EDGE_B, 1'b1, 1'b1, $urandom);
        send_event(qcr_pkg::CMD_SAMPLE, 1'b0, 1'b0, time_snap + 32'd1);
        steady = 1'b0;
    endtask

    // bursts of rotation in one direction closed by a sample, with some noise
    task automatic test_random_traffic();
        logic [15:0] cpr_plan [5];
        int          sent;
        int          len;
        bit          fwd;
        bit          paused;
        logic [1:0]  cmd;
        logic        a;
        logic        b;
        logic [31:0] stamp;
        cpr_plan[0] = 16'd1;
        cpr_plan[1] = 16'd65535;
        cpr_plan[2] = 16'($urandom_range(300, 2));
        cpr_plan[3] = qcr_pkg::CPR_RESET;
        cpr_plan[4] = 16'($urandom_range(65535, 1));
        paused = 1'b0;
        for (int phase = 0; phase < 5; phase++) begin
            set_cpr(cpr_plan[phase]);
            sent = 0;
            while (sent < 80) begin
                fwd = $urandom_range(1);
                len = $urandom_range(24, 1);
                repeat (len) begin
                    a = $urandom_range(1);
                    b = $urandom_range(1);
                    if ($urandom_range(99) < 12) begin
                        cmd = 2'($urandom_range(3));
                    end else begin
                        cmd = $urandom_range(1) ? qcr_pkg::CMD_EDGE_B : qcr_pkg::CMD_EDGE_A;
                        b = ((cmd == qcr_pkg::CMD_EDGE_A) == fwd) ? ~a : a;
                    end
                    send_event(cmd, a, b, $urandom);
                end
                case ($urandom_range(9))
                    0: stamp = time_snap;
                    1: stamp = $urandom;
                    2, 3, 4, 5: stamp = time_snap + 32'($urandom_range(20, 1));
                    default: stamp = time_snap + 32'($urandom_range(5000, 1));
                endcase
                send_event(qcr_pkg::CMD_SAMPLE, 1'($urandom_range(1)),
                           1'($urandom_range(1)), stamp);
                sent += len + 1;
                // hold off once mid-phase until the pipeline drains
                if (phase == 1 && !paused && sent >= 55) begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
        end
    endtask

    // main sequence
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_edge_directions();
        test_divisor_extremes();
        test_top_speed();
        test_random_traffic();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_readings.size() != 0) begin
            $error("%0d expected readings never arrived", expected_readings.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("[quadrature_counter_with_rpm_unit] OK");
        end else begin
            $display("[quadrature_counter_with_rpm_unit] ERROR");
        end
        $finish;
    end

endmodule
